// ----- hdl/bba_pkg.sv -----
// Package for the buddy block allocator: sizes, node codes, payload types,
// and the command and status structs between controller and datapath.
// Depends on nothing.
`default_nettype none
package bba_pkg;

	localparam int POOL_BYTES      = 32768;
	localparam int MIN_BLOCK_BYTES = 32;
	localparam int NODE_COUNT      = 2047;

	// Level of the leaves: the root is level 0.
	localparam int LEAF_LEVEL = $clog2(POOL_BYTES / MIN_BLOCK_BYTES);
	localparam int LEVEL_W    = $clog2(LEAF_LEVEL + 2);
	// Node index wide enough for a child index past the last node.
	localparam int NODE_W     = $clog2(2 * NODE_COUNT + 1);
	localparam int ADDR_W     = $clog2(NODE_COUNT);
	localparam int SPAN_W     = $clog2(POOL_BYTES) + 1;

	localparam logic [1:0] ST_FREE  = 2'd0;
	localparam logic [1:0] ST_SPLIT = 2'd1;
	localparam logic [1:0] ST_USED  = 2'd2;

	localparam logic KIND_ALLOC = 1'b0;

	typedef struct packed {
		logic        kind;
		logic [15:0] byte_count;
		logic [14:0] block_offset;
	} req_t;

	typedef struct packed {
		logic        status;
		logic [14:0] granted_offset;
	} rsp_t;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_CLR,
		OP_LOAD,
		OP_GROW,
		OP_WR_USED,
		OP_WR_SPLIT_DOWN,
		OP_DOWN_LEFT,
		OP_SIBLING,
		OP_PARENT_BASE,
		OP_WR_FREE,
		OP_DOWN_BY_OFF,
		OP_PARENT,
		OP_MERGE,
		OP_RES_FAIL,
		OP_RES_FREE,
		OP_OUT
	} dp_op_t;

	typedef struct packed {
		dp_op_t op;
		logic   rd_kids;
	} dp_cmd_t;

	typedef struct packed {
		logic [1:0] st;
		logic       oob;
		logic       lvl_eq;
		logic       lvl_gt;
		logic       at_leaf;
		logic       is_root;
		logic       is_left;
		logic       base_hit;
		logic       kind;
		logic       size_bad;
		logic       want_lt;
		logic       kids_free;
		logic       clr_last;
		logic       out_free;
	} dp_stat_t;

endpackage
`default_nettype wire

// ----- hdl/buddy_block_allocator_core.sv -----
// Top level of the buddy block allocator: controller plus datapath.
// Depends on bba_pkg, bba_ctl and bba_dp.
//
//   channel   signals                        moves
//   request   req_valid, req_ready, req      one allocate or free per transfer
//   response  rsp_valid, rsp_ready, rsp      one result per request
//
// One request at a time. A refused allocation size goes straight to the result. An
// allocation first doubles the wanted block size until it holds the request, then
// walks the tree depth-first with one node read per step, backtracking where a branch
// is used or too deep. A free descends by offset to the used block, frees it if its
// base matches the offset, then climbs to the root and merges free buddies on the way.
// The single node state memory with its registered read paces each walk.
// After reset the block sweeps the memory to free, one node per cycle,
// and holds req_ready low until the sweep ends.
// A waiting response does not stop the next request from being taken; that
// request's walk then holds its result until the response register frees.
`default_nettype none
module buddy_block_allocator_core (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          req_valid,
	output logic               req_ready,
	input  wire bba_pkg::req_t req,
	output logic               rsp_valid,
	input  wire logic          rsp_ready,
	output bba_pkg::rsp_t      rsp
);
	import bba_pkg::*;

	// Commands flow from the controller, status flows back from the datapath.
	dp_cmd_t  cmd;
	dp_stat_t stat;

	bba_ctl u_ctl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	bba_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

endmodule
`default_nettype wire

// ----- hdl/bba_dp.sv -----
// Datapath of the buddy block allocator: node state memory, walk registers
// and result register. Depends on bba_pkg.
`default_nettype none
module bba_dp (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire bba_pkg::dp_cmd_t cmd,
	output bba_pkg::dp_stat_t    stat,
	input  wire bba_pkg::req_t   req,
	output logic                 rsp_valid,
	input  wire logic            rsp_ready,
	output bba_pkg::rsp_t        rsp
);
	import bba_pkg::*;

	logic [1:0]         mem [NODE_COUNT];
	logic [1:0]         rd_a_q, rd_b_q;
	logic [ADDR_W-1:0]  addr_a, addr_b, wr_addr;
	logic [1:0]         wr_data;
	logic               wr_en;
	logic [ADDR_W-1:0]  clr_q;

	logic               kind_q;
	logic [15:0]        size_q;
	logic [14:0]        off_q;
	logic [SPAN_W-1:0]  want_q;
	logic [LEVEL_W-1:0] wlvl_q;
	logic [NODE_W-1:0]  n_q;
	logic [LEVEL_W-1:0] lvl_q;
	logic [15:0]        base_q;
	logic               res_status_q;
	logic [14:0]        res_off_q;
	logic               rsp_valid_q;
	rsp_t               rsp_q;

	logic [SPAN_W-1:0]  span, half;
	logic [NODE_W-1:0]  left_n, right_n, parent_n;
	logic [SPAN_W:0]    mid;

	assign span     = SPAN_W'(POOL_BYTES) >> lvl_q;
	assign half     = span >> 1;
	assign left_n   = {n_q[NODE_W-2:0], 1'b1};
	assign right_n  = {n_q[NODE_W-2:0], 1'b0} + NODE_W'(2);
	assign parent_n = (n_q - NODE_W'(1)) >> 1;
	assign mid      = (SPAN_W+1)'(base_q) + (SPAN_W+1)'(half);

	assign addr_a = cmd.rd_kids ? left_n[ADDR_W-1:0] : n_q[ADDR_W-1:0];
	assign addr_b = right_n[ADDR_W-1:0];

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = n_q[ADDR_W-1:0];
		wr_data = ST_FREE;
		unique case (cmd.op)
			OP_CLR: begin
				wr_en   = 1'b1;
				wr_addr = clr_q;
			end
			OP_WR_USED: begin
				wr_en   = 1'b1;
				wr_data = ST_USED;
			end
			OP_WR_SPLIT_DOWN: begin
				wr_en   = 1'b1;
				wr_data = ST_SPLIT;
			end
			OP_WR_FREE, OP_MERGE: begin
				wr_en = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_a_q <= mem[addr_a];
		rd_b_q <= mem[addr_b];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cmd.op == OP_CLR) begin
				clr_q <= clr_q + ADDR_W'(1);
			end
			if (cmd.op == OP_OUT) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (cmd.op)
			OP_LOAD: begin
				kind_q <= req.kind;
				size_q <= req.byte_count;
				off_q  <= req.block_offset;
				want_q <= SPAN_W'(MIN_BLOCK_BYTES);
				wlvl_q <= LEVEL_W'(LEAF_LEVEL);
				n_q    <= '0;
				lvl_q  <= '0;
				base_q <= '0;
			end
			OP_GROW: begin
				want_q <= want_q << 1;
				wlvl_q <= wlvl_q - LEVEL_W'(1);
			end
			OP_WR_USED: begin
				res_status_q <= 1'b0;
				res_off_q    <= base_q[14:0];
			end
			OP_WR_SPLIT_DOWN, OP_DOWN_LEFT: begin
				n_q   <= left_n;
				lvl_q <= lvl_q + LEVEL_W'(1);
			end
			OP_SIBLING: begin
				n_q    <= n_q + NODE_W'(1);
				base_q <= base_q + span[15:0];
			end
			OP_PARENT_BASE: begin
				n_q    <= parent_n;
				lvl_q  <= lvl_q - LEVEL_W'(1);
				base_q <= base_q - span[15:0];
			end
			OP_DOWN_BY_OFF: begin
				lvl_q <= lvl_q + LEVEL_W'(1);
				if ((SPAN_W+1)'(off_q) < mid) begin
					n_q <= left_n;
				end else begin
					n_q    <= right_n;
					base_q <= mid[15:0];
				end
			end
			OP_PARENT: begin
				n_q   <= parent_n;
				lvl_q <= lvl_q - LEVEL_W'(1);
			end
			OP_RES_FAIL: begin
				res_status_q <= 1'b1;
				res_off_q    <= '0;
			end
			OP_RES_FREE: begin
				res_status_q <= 1'b0;
				res_off_q    <= '0;
			end
			OP_OUT: begin
				rsp_q.status         <= res_status_q;
				rsp_q.granted_offset <= res_off_q;
			end
			default: begin
			end
		endcase
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	always_comb begin
		stat.st        = rd_a_q;
		stat.oob       = n_q >= NODE_W'(NODE_COUNT);
		stat.lvl_eq    = lvl_q == wlvl_q;
		stat.lvl_gt    = lvl_q > wlvl_q;
		stat.at_leaf   = lvl_q >= LEVEL_W'(LEAF_LEVEL);
		stat.is_root   = n_q == '0;
		stat.is_left   = n_q[0];
		stat.base_hit  = base_q == {1'b0, off_q};
		stat.kind      = kind_q;
		stat.size_bad  = (size_q == '0) || ((SPAN_W+1)'(size_q) > (SPAN_W+1)'(POOL_BYTES));
		stat.want_lt   = (SPAN_W+1)'(want_q) < (SPAN_W+1)'(size_q);
		stat.kids_free = (right_n < NODE_W'(NODE_COUNT)) && (rd_a_q == ST_FREE)
			&& (rd_b_q == ST_FREE);
		stat.clr_last  = clr_q == ADDR_W'(NODE_COUNT - 1);
		stat.out_free  = !rsp_valid_q || rsp_ready;
	end

endmodule
`default_nettype wire

// ----- hdl/bba_ctl.sv -----
// Controller of the buddy block allocator: sequences the clearing pass,
// the allocation walk and the free walk. Depends on bba_pkg.
`default_nettype none
module bba_ctl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              req_valid,
	output logic                   req_ready,
	input  wire bba_pkg::dp_stat_t stat,
	output bba_pkg::dp_cmd_t       cmd
);
	import bba_pkg::*;

	typedef enum logic [12:0] {
		S_CLEAR = 13'b0000000000001,
		S_IDLE  = 13'b0000000000010,
		S_CHECK = 13'b0000000000100,
		S_SIZE  = 13'b0000000001000,
		S_A_RD  = 13'b0000000010000,
		S_A_EV  = 13'b0000000100000,
		S_A_UP  = 13'b0000001000000,
		S_R_RD  = 13'b0000010000000,
		S_R_EV  = 13'b0000100000000,
		S_R_UP  = 13'b0001000000000,
		S_U_RD  = 13'b0010000000000,
		S_U_EV  = 13'b0100000000000,
		S_FIN   = 13'b1000000000000
	} state_t;

	state_t state_q, state_d;

	assign req_ready = state_q == S_IDLE;

	always_comb begin
		state_d     = state_q;
		cmd.op      = OP_NONE;
		cmd.rd_kids = 1'b0;
		unique case (state_q)
			S_CLEAR: begin
				cmd.op = OP_CLR;
				if (stat.clr_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (req_valid) begin
					cmd.op  = OP_LOAD;
					state_d = S_CHECK;
				end
			end
			S_CHECK: begin
				if (stat.kind != KIND_ALLOC) begin
					state_d = S_R_RD;
				end else if (stat.size_bad) begin
					cmd.op  = OP_RES_FAIL;
					state_d = S_FIN;
				end else begin
					state_d = S_SIZE;
				end
			end
			S_SIZE: begin
				if (stat.want_lt) begin
					cmd.op = OP_GROW;
				end else begin
					state_d = S_A_RD;
				end
			end
			S_A_RD: state_d = S_A_EV;
			S_A_EV: begin
				if (stat.oob || stat.st == ST_USED || stat.lvl_gt) begin
					state_d = S_A_UP;
				end else if (stat.st == ST_FREE) begin
					if (stat.lvl_eq) begin
						cmd.op  = OP_WR_USED;
						state_d = S_FIN;
					end else if (stat.at_leaf) begin
						state_d = S_A_UP;
					end else begin
						cmd.op  = OP_WR_SPLIT_DOWN;
						state_d = S_A_RD;
					end
				end else begin
					cmd.op  = OP_DOWN_LEFT;
					state_d = S_A_RD;
				end
			end
			S_A_UP: begin
				if (stat.is_root) begin
					cmd.op  = OP_RES_FAIL;
					state_d = S_FIN;
				end else if (stat.is_left) begin
					cmd.op  = OP_SIBLING;
					state_d = S_A_RD;
				end else begin
					cmd.op = OP_PARENT_BASE;
				end
			end
			S_R_RD: state_d = S_R_EV;
			S_R_EV: begin
				if (stat.oob || stat.st == ST_FREE) begin
					state_d = S_R_UP;
				end else if (stat.st == ST_USED) begin
					if (stat.base_hit) begin
						cmd.op = OP_WR_FREE;
					end
					state_d = S_R_UP;
				end else begin
					cmd.op  = OP_DOWN_BY_OFF;
					state_d = S_R_RD;
				end
			end
			S_R_UP: begin
				if (stat.is_root) begin
					cmd.op  = OP_RES_FREE;
					state_d = S_FIN;
				end else begin
					cmd.op  = OP_PARENT;
					state_d = S_U_RD;
				end
			end
			S_U_RD: begin
				cmd.rd_kids = 1'b1;
				state_d     = S_U_EV;
			end
			S_U_EV: begin
				if (stat.kids_free) begin
					cmd.op = OP_MERGE;
				end
				state_d = S_R_UP;
			end
			S_FIN: begin
				if (stat.out_free) begin
					cmd.op  = OP_OUT;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

endmodule
`default_nettype wire
